// File: design/uudec_pkg.sv
package uudec_pkg;

    // Default width of the running count of decoded bytes.
    localparam int unsigned COUNT_WIDTH_DEF = 16;

    // Width and reset value of the output budget register.
    localparam int unsigned LIMIT_WIDTH = 16;
    localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 16'hFFFF;

    // Characters the decoder looks for.
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_END     = 8'h65;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;

    // Length of the opening keyword and the line length that marks an end line.
    localparam logic [2:0] BEGIN_LEN   = 3'd5;
    localparam logic [5:0] END_LENGTH  = 6'd5;

    typedef enum logic [2:0] {
        PH_BEGIN,
        PH_HEADER,
        PH_LINE,
        PH_DATA,
        PH_PAD,
        PH_HALT
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_END,
        KIND_NOBEG,
        KIND_STOP
    } t_kind;

    // Word held in the input register.
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } t_in_stage;

    // Characters of the opening keyword, one per match position.
    function automatic logic [7:0] begin_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0: c = 8'h62;
            3'd1: c = 8'h65;
            3'd2: c = 8'h67;
            3'd3: c = 8'h69;
            3'd4: c = 8'h6E;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Six-bit value carried by one encoded character.
    function automatic logic [5:0] sextet(input logic [7:0] c);
        logic [7:0] d;
        d = c - CHAR_SPACE;
        return d[5:0];
    endfunction

endpackage

// File: design/uudec_ifs.sv
// Channel carrying encoded characters into the decoder.
interface uudec_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

// Channel carrying decoded results out of the decoder.
interface uudec_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] out_kind;
    logic       out_limit_hit;

    modport source (output valid, output out_byte, output out_kind, output out_limit_hit,
                    input ready);
    modport sink   (input valid, input out_byte, input out_kind, input out_limit_hit,
                    output ready);
endinterface

// File: design/uudec_in_reg.sv
module uudec_in_reg (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    uudec_in_if.sink              i_in,
    input  logic                  i_advance,
    output uudec_pkg::t_in_stage  o_stage
);

    logic       r_valid;
    logic [7:0] r_data;
    logic       accept;

    // The register takes a new word when it is empty or its word moves on.
    assign i_in.ready = !r_valid || i_advance;
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data <= i_in.in_byte;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.data  = r_data;

endmodule

// File: design/uudec_engine.sv
module uudec_engine #(
    parameter int unsigned COUNT_WIDTH = uudec_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  uudec_pkg::t_in_stage                i_stage,
    input  logic [uudec_pkg::LIMIT_WIDTH-1:0]   i_output_limit,
    output logic                                o_advance,
    uudec_out_if.source                         o_res
);

    localparam int unsigned XW =
        ((COUNT_WIDTH > uudec_pkg::LIMIT_WIDTH) ? COUNT_WIDTH : uudec_pkg::LIMIT_WIDTH) + 1;

    // Decoder state.
    uudec_pkg::t_phase      r_phase, n_phase;
    logic [2:0]             r_match, n_match;
    logic [5:0]             r_left, n_left;
    logic [1:0]             r_pos, n_pos;
    logic [5:0]             r_prev, n_prev;
    logic [COUNT_WIDTH-1:0] r_count, n_count;

    // Result register.
    logic                   r_out_valid;
    logic [7:0]             r_out_byte;
    uudec_pkg::t_kind       r_out_kind;
    logic                   r_out_hit;

    // Result of the word being processed.
    logic                   emit;
    logic [7:0]             e_byte;
    uudec_pkg::t_kind       e_kind;
    logic                   e_hit;

    logic [7:0]             c;
    logic [5:0]             s;
    logic [XW-1:0]          limit_x;
    logic [XW-1:0]          count_x;
    logic [XW-1:0]          room_x;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic [5:0]             left_dec;

    // A word moves on when the result register is free or being emptied.
    assign o_advance = i_stage.valid && (!r_out_valid || o_res.ready);

    assign c         = i_stage.data;
    assign s         = uudec_pkg::sextet(c);
    assign limit_x   = XW'(i_output_limit);
    assign count_x   = XW'(r_count);
    assign room_x    = (limit_x > count_x) ? (limit_x - count_x) : '0;
    assign count_inc = r_count + 1'b1;
    assign left_dec  = (r_left != 6'd0) ? (r_left - 6'd1) : 6'd0;

    // Next state and result for one character.
    always_comb begin
        n_phase = r_phase;
        n_match = r_match;
        n_left  = r_left;
        n_pos   = r_pos;
        n_prev  = r_prev;
        n_count = r_count;
        emit    = 1'b0;
        e_byte  = 8'h00;
        e_kind  = uudec_pkg::KIND_DATA;
        e_hit   = 1'b0;
        if (o_advance) begin
            case (r_phase)
                uudec_pkg::PH_BEGIN: begin
                    if (r_match < uudec_pkg::BEGIN_LEN && c == uudec_pkg::begin_char(r_match)) begin
                        if (r_match + 3'd1 == uudec_pkg::BEGIN_LEN) begin
                            n_match = 3'd0;
                            n_phase = uudec_pkg::PH_HEADER;
                        end else begin
                            n_match = r_match + 3'd1;
                        end
                    end else begin
                        n_match = 3'd0;
                        emit    = 1'b1;
                        e_kind  = uudec_pkg::KIND_NOBEG;
                    end
                end
                uudec_pkg::PH_HEADER, uudec_pkg::PH_PAD: begin
                    if (c == uudec_pkg::CHAR_NEWLINE) begin
                        n_phase = uudec_pkg::PH_LINE;
                    end
                end
                uudec_pkg::PH_LINE: begin
                    if (c == uudec_pkg::CHAR_NEWLINE) begin
                        n_phase = r_phase;
                    end else if (s == 6'd0) begin
                        n_phase = uudec_pkg::PH_HALT;
                        emit    = 1'b1;
                        e_kind  = uudec_pkg::KIND_STOP;
                    end else if (s == uudec_pkg::END_LENGTH && c == uudec_pkg::CHAR_END) begin
                        n_phase = uudec_pkg::PH_BEGIN;
                        n_match = 3'd0;
                        emit    = 1'b1;
                        e_kind  = uudec_pkg::KIND_END;
                    end else if (room_x == '0) begin
                        n_phase = uudec_pkg::PH_HALT;
                    end else begin
                        // Clamp the line length to the remaining budget.
                        n_left  = (room_x < XW'(s)) ? room_x[5:0] : s;
                        n_pos   = 2'd0;
                        n_phase = uudec_pkg::PH_DATA;
                    end
                end
                uudec_pkg::PH_DATA: begin
                    n_pos  = r_pos + 2'd1;
                    n_prev = s;
                    if (r_pos != 2'd0) begin
                        case (r_pos)
                            2'd1:    e_byte = {r_prev, s[5:4]};
                            2'd2:    e_byte = {r_prev[3:0], s[5:2]};
                            default: e_byte = {r_prev[1:0], s};
                        endcase
                        emit    = 1'b1;
                        e_kind  = uudec_pkg::KIND_DATA;
                        n_count = count_inc;
                        n_left  = left_dec;
                        if (XW'(count_inc) >= limit_x) begin
                            e_hit   = 1'b1;
                            n_phase = uudec_pkg::PH_HALT;
                        end else if (left_dec == 6'd0) begin
                            n_phase = uudec_pkg::PH_PAD;
                        end
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= uudec_pkg::PH_BEGIN;
            r_match <= 3'd0;
            r_left  <= 6'd0;
            r_pos   <= 2'd0;
            r_prev  <= 6'd0;
            r_count <= '0;
        end else begin
            r_phase <= n_phase;
            r_match <= n_match;
            r_left  <= n_left;
            r_pos   <= n_pos;
            r_prev  <= n_prev;
            r_count <= n_count;
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_advance) begin
            r_out_valid <= emit;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (o_advance && emit) begin
            r_out_byte <= e_byte;
            r_out_kind <= e_kind;
            r_out_hit  <= e_hit;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.out_byte      = r_out_byte;
    assign o_res.out_kind      = r_out_kind;
    assign o_res.out_limit_hit = r_out_hit;

endmodule

// File: design/uudecode_stream_decoder_core.sv
// Streaming uudecode: takes one encoded character per word and gives at most one result word
// per character (a decoded byte, an end line, a missing keyword error or an empty line stop).
// A character is accepted in every cycle while results are taken; a result passes through the
// input register and then the result register before it is presented.
// Input ready follows output ready combinationally when both registers are full. After a stop
// or a used-up budget the block ignores all input until reset. The user must write the budget
// register only while the block is idle; the block itself does not enforce this.
module uudecode_stream_decoder_core #(
    parameter int unsigned COUNT_WIDTH = uudec_pkg::COUNT_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [uudec_pkg::LIMIT_WIDTH-1:0]  i_cfg_wr_data,
    uudec_in_if.sink                           i_in,
    uudec_out_if.source                        o_out
);

    logic [uudec_pkg::LIMIT_WIDTH-1:0] r_output_limit;
    uudec_pkg::t_in_stage              stage;
    logic                              advance;

    // Output budget register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_output_limit <= uudec_pkg::LIMIT_RESET;
        end else if (i_cfg_wr_en) begin
            r_output_limit <= i_cfg_wr_data;
        end
    end

    uudec_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (advance),
        .o_stage   (stage)
    );

    uudec_engine #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_stage        (stage),
        .i_output_limit (r_output_limit),
        .o_advance      (advance),
        .o_res          (o_out)
    );

endmodule

// File: tb/uudecode_stream_decoder_core_tb.sv
`timescale 1ns / 100ps

module uudecode_stream_decoder_core_tb;
    import uudec_pkg::*;

    // Cycles the pipeline may still be busy after the last expected word.
    localparam int SETTLE_CYCLES = 6;
    localparam logic [39:0] KEYWORD = "begin";

    typedef struct packed {
        logic [7:0] data;
        t_kind      kind;
        logic       hit;
    } t_decoded_word;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic [LIMIT_WIDTH-1:0] i_cfg_wr_data;

    uudec_in_if  in_ch ();
    uudec_out_if out_ch ();

    uudecode_stream_decoder_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (in_ch),
        .o_out         (out_ch)
    );

    // Decoder state as the testbench expects it to be.
    t_phase                 dec_phase;
    logic [2:0]             match_cnt;
    logic [5:0]             bytes_left;
    logic [1:0]             grp_pos;
    logic [5:0]             prev_six;
    logic [15:0]            dec_count;
    logic [LIMIT_WIDTH-1:0] budget;

    t_decoded_word pending_words[$];
    int  error_count;
    int  chars_sent;
    int  budget_writes;
    int  n_data, n_end, n_nobeg, n_stop, n_hit;
    bit  no_idle;
    string halt_case;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog for a hung handshake.
    initial begin
        #400_000;
        $display("simulation failed");
        $finish;
    end

    // Work out what one accepted character must produce and queue it.
    task automatic decode_char(input logic [7:0] c);
        logic [7:0] diff;
        logic [5:0] six;
        logic [5:0] len;
        logic [15:0] room;
        logic [7:0] data;
        logic [1:0] pos;
        logic hit;
        diff = c - CHAR_SPACE;
        six = diff[5:0];
        case (dec_phase)
            PH_BEGIN: begin
                if (c == KEYWORD[8*(4-match_cnt) +: 8]) begin
                    match_cnt = match_cnt + 3'd1;
                    if (match_cnt == BEGIN_LEN) begin
                        match_cnt = 3'd0;
                        dec_phase = PH_HEADER;
                    end
                end else begin
                    match_cnt = 3'd0;
                    pending_words.push_back('{8'h00, KIND_NOBEG, 1'b0});
                end
            end
            PH_HEADER, PH_PAD: begin
                if (c == CHAR_NEWLINE) dec_phase = PH_LINE;
            end
            PH_LINE: begin
                if (c == CHAR_NEWLINE) begin
                    // A blank line before the length character is skipped.
                end else if (six == 6'd0) begin
                    dec_phase = PH_HALT;
                    pending_words.push_back('{8'h00, KIND_STOP, 1'b0});
                end else if (six == END_LENGTH && c == CHAR_END) begin
                    dec_phase = PH_BEGIN;
                    match_cnt = 3'd0;
                    pending_words.push_back('{8'h00, KIND_END, 1'b0});
                end else begin
                    room = (budget > dec_count) ? budget - dec_count : 16'd0;
                    if (room == 16'd0) begin
                        dec_phase = PH_HALT;
                    end else begin
                        len = (room < {10'd0, six}) ? room[5:0] : six;
                        bytes_left = len;
                        grp_pos = 2'd0;
                        dec_phase = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                pos = grp_pos;
                grp_pos = grp_pos + 2'd1;
                if (pos == 2'd0) begin
                    prev_six = six;
                end else begin
                    // Four sextets carry three bytes; each position takes its slice.
                    case (pos)
                        2'd1:    data = {prev_six, six[5:4]};
                        2'd2:    data = {prev_six[3:0], six[5:2]};
                        default: data = {prev_six[1:0], six};
                    endcase
                    prev_six = six;
                    dec_count = dec_count + 16'd1;
                    if (bytes_left != 6'd0) bytes_left = bytes_left - 6'd1;
                    hit = 1'b0;
                    if (dec_count >= budget) begin
                        hit = 1'b1;
                        dec_phase = PH_HALT;
                    end else if (bytes_left == 6'd0) begin
                        dec_phase = PH_PAD;
                    end
                    pending_words.push_back('{data, KIND_DATA, hit});
                end
            end
            default: begin
            end
        endcase
    endtask

    // Send one character word, with a random gap in front unless bursting.
    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= c;
        do @(posedge i_clk); while (!(in_ch.valid === 1'b1 && in_ch.ready === 1'b1));
        decode_char(c);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        foreach (s[i]) send_char(s[i]);
    endtask

    // Stop sending and let every expected word come out.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_budget(input logic [LIMIT_WIDTH-1:0] value);
        wait_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        budget = value;
        budget_writes++;
    endtask

    function automatic logic [7:0] text_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == CHAR_NEWLINE);
        return c;
    endfunction

    // Any character whose sextet is n, other than the end marker and newline.
    function automatic logic [7:0] length_char(input int n);
        logic [7:0] c;
        do c = 8'(n + 32 + 64 * $urandom_range(0, 3));
        while (c == CHAR_END || c == CHAR_NEWLINE);
        return c;
    endfunction

    // Keyword, a few header characters and the newline that closes the header.
    task automatic send_header();
        send_text("begin");
        repeat ($urandom_range(0, 4)) send_char(text_char());
        send_char(CHAR_NEWLINE);
    endtask

    // Length character and just enough data characters for n bytes.
    task automatic send_line(input int n);
        int chars;
        chars = 4 * (n / 3) + ((n % 3 != 0) ? n % 3 + 1 : 0);
        send_char(length_char(n));
        repeat (chars) send_char(8'($urandom_range(0, 255)));
    endtask

    // Random ready stalls on the result side.
    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 6);
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid === 1'b1 && out_ch.ready === 1'b1));
        end
    end

    // Compare every result word with the oldest expectation.
    always @(posedge i_clk) begin
        t_decoded_word want;
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (pending_words.size() == 0) begin
                $error("unexpected result word: out_byte %02h out_kind %0d out_limit_hit %0b",
                       out_ch.out_byte, out_ch.out_kind, out_ch.out_limit_hit);
                error_count++;
            end else begin
                want = pending_words.pop_front();
                if (out_ch.out_byte !== want.data) begin
                    $error("out_byte mismatch: expected %02h, got %02h",
                           want.data, out_ch.out_byte);
                    error_count++;
                end
                if (out_ch.out_kind !== want.kind) begin
                    $error("out_kind mismatch: expected %0d, got %0d",
                           want.kind, out_ch.out_kind);
                    error_count++;
                end
                if (out_ch.out_limit_hit !== want.hit) begin
                    $error("out_limit_hit mismatch: expected %0b, got %0b",
                           want.hit, out_ch.out_limit_hit);
                    error_count++;
                end
                case (want.kind)
                    KIND_DATA:  n_data++;
                    KIND_END:   n_end++;
                    KIND_NOBEG: n_nobeg++;
                    default:    n_stop++;
                endcase
                if (want.hit) n_hit++;
            end
        end
    end

    // Keyword mismatches, a repeated first letter, then a header line.
    task automatic test_keyword_search();
        send_text("bb");
        send_text("begin");
        send_char(8'h58);
        send_char(CHAR_NEWLINE);
    endtask

    // Blank line, a one-byte line with extreme characters, and a line of five
    // bytes whose data holds newlines.
    task automatic test_line_decoding();
        send_char(CHAR_NEWLINE);
        send_char(8'h21);
        send_char(8'h00);
        send_char(8'hFF);
        send_char(CHAR_NEWLINE);
        send_char(8'hE5);
        send_char(CHAR_NEWLINE);
        send_char(8'hFF);
        send_char(8'h00);
        send_char(8'h41);
        send_char(8'h7E);
        send_char(CHAR_NEWLINE);
        send_char(8'h33);
        send_char(CHAR_NEWLINE);
    endtask

    // A blank line, then the end marker as a line length.
    task automatic test_end_line();
        send_char(CHAR_NEWLINE);
        send_char(CHAR_END);
    endtask

    // Whole encoded files with random content, plus some broken keywords and noise.
    task automatic test_random_files(input int target);
        int lines;
        while (chars_sent < target) begin
            no_idle = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(0, 2)) send_char(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 7) == 0) begin
                send_text("beg");
                send_char(text_char());
            end
            send_header();
            lines = $urandom_range(1, 4);
            repeat (lines) begin
                if ($urandom_range(0, 5) == 0) send_char(CHAR_NEWLINE);
                send_line(($urandom_range(0, 4) == 0) ? $urandom_range(1, 63)
                                                       : $urandom_range(1, 9));
                repeat ($urandom_range(0, 2)) send_char(text_char());
                send_char(CHAR_NEWLINE);
            end
            send_char(CHAR_END);
            if ($urandom_range(0, 1) == 0) send_text("nd\n");
            no_idle = 1'b0;
            // Now and then hold off until the result side has drained.
            if ($urandom_range(0, 7) == 0) wait_idle();
        end
    endtask

    // A budget of one while only the keyword search runs, then a large one.
    task automatic test_budget_register();
        set_budget(16'd1);
        send_text("xbe");
        set_budget(16'($urandom_range(2000, 65534)));
    endtask

    // One of the ways the decoder halts, then characters that must be ignored.
    task automatic test_halt();
        int k;
        case ($urandom_range(0, 3))
            0: begin
                halt_case = "empty line stop";
                send_header();
                send_line($urandom_range(1, 9));
                send_char(CHAR_NEWLINE);
                send_char(8'(32 + 64 * $urandom_range(0, 3)));
            end
            1: begin
                halt_case = "budget reached inside a clamped line";
                k = $urandom_range(1, 20);
                set_budget(dec_count + 16'(k));
                send_header();
                send_line($urandom_range(k + 1, 63));
            end
            2: begin
                halt_case = "no budget at line start";
                set_budget(16'd1);
                send_header();
                send_char(length_char($urandom_range(1, 63)));
            end
            default: begin
                halt_case = "budget lowered in the middle of a line";
                send_header();
                send_char(length_char($urandom_range(10, 30)));
                repeat (3) send_char(8'($urandom_range(0, 255)));
                set_budget(16'd1);
                repeat (3) send_char(8'($urandom_range(0, 255)));
            end
        endcase
        repeat (4) send_char(8'($urandom_range(0, 255)));
    endtask

    // Test sequence.
    initial begin
        in_ch.valid   <= 1'b0;
        in_ch.in_byte <= 8'h00;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        i_rst_n       <= 1'b0;
        dec_phase  = PH_BEGIN;
        match_cnt  = 3'd0;
        bytes_left = 6'd0;
        grp_pos    = 2'd0;
        prev_six   = 6'd0;
        dec_count  = 16'd0;
        budget     = LIMIT_RESET;
        no_idle    = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_budget(16'hFFFF);
        test_keyword_search();
        test_line_decoding();
        test_end_line();
        test_random_files(270);
        test_budget_register();
        test_random_files(520);
        test_halt();

        // Drain with a bound, then look for leftover expectations.
        in_ch.valid <= 1'b0;
        for (int i = 0; i < 2000 && pending_words.size() != 0; i++) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_words.size() != 0) begin
            $error("%0d expected result words never arrived", pending_words.size());
            error_count++;
        end

        $display("Sent %0d characters and checked %0d data bytes, %0d end lines,",
                 chars_sent, n_data, n_end);
        $display("%0d keyword errors, %0d stops, %0d budget hits; %0d budget writes; halt: %s.",
                 n_nobeg, n_stop, n_hit, budget_writes, halt_case);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: uudecode_stream_decoder_core.f
design/uudec_pkg.sv
design/uudec_ifs.sv
design/uudec_in_reg.sv
design/uudec_engine.sv
design/uudecode_stream_decoder_core.sv
tb/uudecode_stream_decoder_core_tb.sv
